// File: rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// shared types and constants for the decimal scale aligner
// ----------------------------------------------------------------------------
`default_nettype none

package dsa_pkg;

   localparam int MAX_SCALE_DEF = 28;
   localparam int LOW_W         = 64;
   localparam int HIGH_W        = 32;
   localparam int SCALE_W       = 8;
   localparam int COMMON_W      = 5;
   localparam int WORD_W        = 64;
   localparam int WIDE_W        = 3 * WORD_W;
   localparam int NARROW_W      = LOW_W + HIGH_W;

   typedef struct packed {
      logic [LOW_W-1:0]   a_mantissa_low;
      logic [HIGH_W-1:0]  a_mantissa_high;
      logic [SCALE_W-1:0] a_scale;
      logic [LOW_W-1:0]   b_mantissa_low;
      logic [HIGH_W-1:0]  b_mantissa_high;
      logic [SCALE_W-1:0] b_scale;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   a_word0;
      logic [WORD_W-1:0]   a_word1;
      logic [WORD_W-1:0]   a_word2;
      logic [WORD_W-1:0]   b_word0;
      logic [WORD_W-1:0]   b_word1;
      logic [WORD_W-1:0]   b_word2;
      logic [COMMON_W-1:0] common_scale;
      logic                scale_error;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/dsa_times_ten.sv
// ----------------------------------------------------------------------------
// dsa_times_ten
// shared multiply-by-ten unit, x*8 + x*2 modulo 2^192
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_times_ten (
   input  wire logic [dsa_pkg::WIDE_W-1:0] operand,
   output logic      [dsa_pkg::WIDE_W-1:0] product
);
   import dsa_pkg::*;

   logic [WIDE_W-1:0] times_eight;
   logic [WIDE_W-1:0] times_two;

   assign times_eight = {operand[WIDE_W-4:0], 3'b000};
   assign times_two   = {operand[WIDE_W-2:0], 1'b0};
   assign product     = times_eight + times_two;

endmodule

`default_nettype wire

// File: rtl/decimal_scale_aligner_top.sv
// ----------------------------------------------------------------------------
// decimal_scale_aligner_top
// aligns two 96-bit decimal mantissas to a common power-of-ten scale
// ----------------------------------------------------------------------------
//  channel  dir  handshake            word
//  req      in   req_valid/req_stall  req_type: two mantissas and scales
//  rsp      out  rsp_valid/rsp_stall  rsp_type: two 192-bit mantissas, scale
//
//  after accept the sequencer stays in ST_RUN for |a_scale - b_scale| multiplies
//  by ten, then offers the result in ST_DONE (straight there on error or equal scales)
//  one multiply-by-ten per cycle in ST_RUN through the shared 192-bit shift-add unit
//  req_stall is high from accept until the result word is taken
//  synchronous active-high reset returns the sequencer to idle
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_scale_aligner_top #(
   parameter int MAX_SCALE = dsa_pkg::MAX_SCALE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dsa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dsa_pkg::rsp_type      rsp_data
);
   import dsa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [WIDE_W-1:0]   a_ff, a_in;
   logic [WIDE_W-1:0]   b_ff, b_in;
   logic [COMMON_W-1:0] cnt_ff, cnt_in;
   logic                sel_a_ff, sel_a_in;
   logic [COMMON_W-1:0] common_ff, common_in;
   logic                err_ff, err_in;

   logic [WIDE_W-1:0]   mul_src;
   logic [WIDE_W-1:0]   mul_res;
   logic                bad_scale;
   logic [SCALE_W-1:0]  diff;

   assign mul_src = sel_a_ff ? a_ff : b_ff;

   dsa_times_ten u_times_ten (
      .operand (mul_src),
      .product (mul_res)
   );

   assign bad_scale = (req_data.a_scale > SCALE_W'(MAX_SCALE)) ||
                      (req_data.b_scale > SCALE_W'(MAX_SCALE));
   assign diff = (req_data.a_scale < req_data.b_scale) ?
                 (req_data.b_scale - req_data.a_scale) :
                 (req_data.a_scale - req_data.b_scale);

   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      cnt_in    = cnt_ff;
      sel_a_in  = sel_a_ff;
      common_in = common_ff;
      err_in    = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in = {{(WIDE_W-NARROW_W){1'b0}},
                       req_data.a_mantissa_high, req_data.a_mantissa_low};
               b_in = {{(WIDE_W-NARROW_W){1'b0}},
                       req_data.b_mantissa_high, req_data.b_mantissa_low};
               sel_a_in = (req_data.a_scale < req_data.b_scale);
               if (bad_scale) begin
                  err_in    = 1'b1;
                  common_in = '0;
                  cnt_in    = '0;
                  state_in  = ST_DONE;
               end else begin
                  err_in    = 1'b0;
                  common_in = (req_data.a_scale < req_data.b_scale) ?
                              req_data.b_scale[COMMON_W-1:0] :
                              req_data.a_scale[COMMON_W-1:0];
                  cnt_in    = diff[COMMON_W-1:0];
                  state_in  = (diff == '0) ? ST_DONE : ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (sel_a_ff) begin
               a_in = mul_res;
            end else begin
               b_in = mul_res;
            end
            cnt_in = cnt_ff - COMMON_W'(1);
            if (cnt_ff == COMMON_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff  <= state_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
         cnt_ff    <= cnt_in;
         sel_a_ff  <= sel_a_in;
         common_ff <= common_in;
         err_ff    <= err_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      rsp_data.a_word0      = a_ff[WORD_W-1:0];
      rsp_data.a_word1      = a_ff[2*WORD_W-1:WORD_W];
      rsp_data.a_word2      = a_ff[WIDE_W-1:2*WORD_W];
      rsp_data.b_word0      = b_ff[WORD_W-1:0];
      rsp_data.b_word1      = b_ff[2*WORD_W-1:WORD_W];
      rsp_data.b_word2      = b_ff[WIDE_W-1:2*WORD_W];
      rsp_data.common_scale = common_ff;
      rsp_data.scale_error  = err_ff;
   end

endmodule

`default_nettype wire

// File: rtl/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// port-level checks for the decimal scale aligner, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module dsa_checker #(
   parameter int MAX_SCALE = dsa_pkg::MAX_SCALE_DEF
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire dsa_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire dsa_pkg::rsp_type rsp_data
);
   import dsa_pkg::*;

   // busy right after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req_stall low right after an accepted word");

   // no new word taken while a result is pending
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result word is pending");

   // error results carry a zero scale
   a_error_scale_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.scale_error) |-> (rsp_data.common_scale == '0))
      else $error("scale error with nonzero common scale");

   // common scale within the format
   a_scale_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.common_scale <= COMMON_W'(MAX_SCALE)))
      else $error("common scale above maximum");

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word dropped or changed");

endmodule

bind decimal_scale_aligner_top dsa_checker #(.MAX_SCALE(MAX_SCALE)) u_dsa_checker (.*);

`default_nettype wire
